FILE: hdl/dcmso_pkg.sv
// dcmso_pkg: shared widths, coefficient table, command struct and step schedule
// for the dc motor state observer core. No dependencies; imported by every module
// in the hdl folder.
package dcmso_pkg;

   // channel store geometry
   localparam int CHANNELS = 2;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // field and datapath widths
   localparam int EST_W     = 48;   // q16.32 estimate
   localparam int VOLT_W    = 16;   // q6.10 voltage
   localparam int ANG_W     = 32;   // q16.16 angle
   localparam int VQ_W      = 38;   // voltage moved to q.32
   localparam int OPND_W    = 49;   // signed multiplier operand
   localparam int MAG_W     = 49;   // operand magnitude
   localparam int LO_W      = 24;   // low operand slice
   localparam int HI_W      = MAG_W - LO_W;
   localparam int COEF_W    = 32;   // coefficient magnitude, scale 2^30
   localparam int LO_PROD_W = LO_W + COEF_W;
   localparam int HI_PROD_W = HI_W + COEF_W;
   localparam int Q_SHIFT   = 30;
   localparam int RSUM_W    = HI_PROD_W + LO_W + 1;
   localparam int RND_W     = RSUM_W - Q_SHIFT;
   localparam int ACC_W     = 56;

   // coefficients premultiplied by dt, magnitude rounded to nearest at scale 2^30
   localparam logic [63:0] Q30 = 64'd1073741824;
   localparam logic [COEF_W-1:0] CF_II_MAG =
      COEF_W'((64'd7241379 * Q30 + 64'd500000000) / 64'd1000000000);
   localparam logic [COEF_W-1:0] CF_IW_MAG =
      COEF_W'((64'd36207 * Q30 + 64'd500000000) / 64'd1000000000);
   localparam logic [COEF_W-1:0] CF_IV_MAG =
      COEF_W'((Q30 + 64'd580) / 64'd1160);
   localparam logic [COEF_W-1:0] CF_IE_MAG =
      COEF_W'((64'd5167 * Q30 + 64'd5000000) / 64'd10000000);
   localparam logic [COEF_W-1:0] CF_WI_MAG =
      COEF_W'((64'd2009569378 * Q30 + 64'd500000000) / 64'd1000000000);
   localparam logic [COEF_W-1:0] CF_WW_MAG =
      COEF_W'((64'd956938 * Q30 + 64'd500000000) / 64'd1000000000);
   localparam logic [COEF_W-1:0] CF_WE_MAG =
      COEF_W'((64'd415731 * Q30 + 64'd5000000) / 64'd10000000);
   localparam logic [COEF_W-1:0] CF_AW_MAG =
      COEF_W'((Q30 + 64'd500) / 64'd1000);
   localparam logic [COEF_W-1:0] CF_AE_MAG =
      COEF_W'((64'd218017 * Q30 + 64'd5000000) / 64'd10000000);

   typedef enum logic [1:0] {
      OP_CUR  = 2'd0,
      OP_SPD  = 2'd1,
      OP_VOLT = 2'd2,
      OP_ERR  = 2'd3
   } opnd_type;

   typedef enum logic [3:0] {
      CF_II = 4'd0,
      CF_IW = 4'd1,
      CF_IV = 4'd2,
      CF_IE = 4'd3,
      CF_WI = 4'd4,
      CF_WW = 4'd5,
      CF_WE = 4'd6,
      CF_AW = 4'd7,
      CF_AE = 4'd8
   } coef_type;

   typedef enum logic [1:0] {
      TGT_CUR = 2'd0,
      TGT_SPD = 2'd1,
      TGT_ANG = 2'd2
   } fin_tgt_type;

   // one cycle of datapath commands
   typedef struct packed {
      logic        load;     // capture a new word and read the channel store
      logic        sel_en;   // register operand magnitude and coefficient
      opnd_type    opnd;
      coef_type    coef;
      logic        mul_lo;   // low partial product
      logic        mul_hi;   // high partial product
      logic        rnd_en;   // merge partials and round
      logic        acc_en;   // add signed term into accumulator
      logic        fin_en;   // saturate accumulator into an estimate
      fin_tgt_type fin_tgt;
      logic        wb;       // write back store and result register
   } ctl_cmd_type;

   localparam int STEP_COUNT = 24;
   localparam int STEP_W     = $clog2(STEP_COUNT);

   function automatic logic [COEF_W-1:0] coef_mag(input coef_type k);
      case (k)
         CF_II:   coef_mag = CF_II_MAG;
         CF_IW:   coef_mag = CF_IW_MAG;
         CF_IV:   coef_mag = CF_IV_MAG;
         CF_IE:   coef_mag = CF_IE_MAG;
         CF_WI:   coef_mag = CF_WI_MAG;
         CF_WW:   coef_mag = CF_WW_MAG;
         CF_WE:   coef_mag = CF_WE_MAG;
         CF_AW:   coef_mag = CF_AW_MAG;
         CF_AE:   coef_mag = CF_AE_MAG;
         default: coef_mag = '0;
      endcase
   endfunction

   function automatic logic coef_neg(input coef_type k);
      case (k)
         CF_II, CF_IW, CF_IE, CF_WW: coef_neg = 1'b1;
         default:                    coef_neg = 1'b0;
      endcase
   endfunction

   // run schedule: each product passes select, low, high, round and accumulate,
   // with successive products overlapping
   function automatic ctl_cmd_type step_cmd(input logic [STEP_W-1:0] step);
      ctl_cmd_type c;
      c = '0;
      case (step)
         5'd0: begin
            c.sel_en = 1'b1; c.opnd = OP_CUR; c.coef = CF_II;
         end
         5'd1: begin
            c.mul_lo = 1'b1;
         end
         5'd2: begin
            c.sel_en = 1'b1; c.opnd = OP_SPD; c.coef = CF_IW;
            c.mul_hi = 1'b1;
         end
         5'd3: begin
            c.mul_lo = 1'b1; c.rnd_en = 1'b1;
         end
         5'd4: begin
            c.sel_en = 1'b1; c.opnd = OP_VOLT; c.coef = CF_IV;
            c.mul_hi = 1'b1; c.acc_en = 1'b1;
         end
         5'd5: begin
            c.mul_lo = 1'b1; c.rnd_en = 1'b1;
         end
         5'd6: begin
            c.sel_en = 1'b1; c.opnd = OP_ERR; c.coef = CF_IE;
            c.mul_hi = 1'b1; c.acc_en = 1'b1;
         end
         5'd7: begin
            c.mul_lo = 1'b1; c.rnd_en = 1'b1;
         end
         5'd8: begin
            c.sel_en = 1'b1; c.opnd = OP_SPD; c.coef = CF_WW;
            c.mul_hi = 1'b1; c.acc_en = 1'b1;
         end
         5'd9: begin
            c.mul_lo = 1'b1; c.rnd_en = 1'b1;
         end
         5'd10: begin
            c.sel_en = 1'b1; c.opnd = OP_ERR; c.coef = CF_WE;
            c.mul_hi = 1'b1; c.acc_en = 1'b1;
         end
         5'd11: begin
            c.mul_lo = 1'b1; c.rnd_en = 1'b1;
            c.fin_en = 1'b1; c.fin_tgt = TGT_CUR;
         end
         5'd12: begin
            c.sel_en = 1'b1; c.opnd = OP_CUR; c.coef = CF_WI;
            c.mul_hi = 1'b1; c.acc_en = 1'b1;
         end
         5'd13: begin
            c.mul_lo = 1'b1; c.rnd_en = 1'b1;
         end
         5'd14: begin
            c.sel_en = 1'b1; c.opnd = OP_ERR; c.coef = CF_AE;
            c.mul_hi = 1'b1; c.acc_en = 1'b1;
         end
         5'd15: begin
            c.mul_lo = 1'b1; c.rnd_en = 1'b1;
         end
         5'd16: begin
            c.mul_hi = 1'b1; c.acc_en = 1'b1;
         end
         5'd17: begin
            c.rnd_en = 1'b1;
            c.fin_en = 1'b1; c.fin_tgt = TGT_SPD;
         end
         5'd18: begin
            c.sel_en = 1'b1; c.opnd = OP_SPD; c.coef = CF_AW;
            c.acc_en = 1'b1;
         end
         5'd19: begin
            c.mul_lo = 1'b1;
         end
         5'd20: begin
            c.mul_hi = 1'b1;
         end
         5'd21: begin
            c.rnd_en = 1'b1;
         end
         5'd22: begin
            c.acc_en = 1'b1;
         end
         5'd23: begin
            c.fin_en = 1'b1; c.fin_tgt = TGT_ANG;
         end
         default: begin
            c = '0;
         end
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/dc_motor_state_observer_core.sv
// dc_motor_state_observer_core: top level of the dc motor luenberger observer.
// Joins dcmso_ctrl and dcmso_datapath; depends on dcmso_pkg.
//
// Each request word selects a motor channel and carries its applied voltage
// (signed q6.10) and measured shaft angle (signed q16.16). The core runs one
// forward-euler step (dt 1 ms) of a third-order observer on that channel:
// current first, then speed from the new current, then angle from the new
// speed, with the angle error taken against the angle estimate held before the
// step. Estimates are signed q16.32, every product is rounded to nearest (ties
// away from zero) and every estimate saturates at 48 bits. The response word
// returns the channel and its three new estimates; the per-channel store
// resets to zero. Once a request word is taken, the single shared 25x32
// multiplier works through nine products, followed by a write-back step; no new
// word is taken until that write-back. The response register is separate from
// the request side, so a new word is taken while the previous response still
// waits on rsp_stall.
// A channel number at or above the channel count leaves the store alone and
// returns zero estimates.
module dc_motor_state_observer_core
   import dcmso_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_chn,
   input  logic signed [VOLT_W-1:0] req_voltage,
   input  logic signed [ANG_W-1:0]  req_measured_angle,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_out_channel,
   output logic signed [EST_W-1:0]  rsp_angle_estimate,
   output logic signed [EST_W-1:0]  rsp_speed_estimate,
   output logic signed [EST_W-1:0]  rsp_current_estimate
);

   // per-cycle commands from the sequencer to the datapath
   ctl_cmd_type cmd;

   // sequencer: handshake, step counter, response valid
   dcmso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath: channel store, multiplier, accumulator, response payload
   dcmso_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_chn              (req_chn),
      .req_voltage          (req_voltage),
      .req_measured_angle   (req_measured_angle),
      .rsp_out_channel      (rsp_out_channel),
      .rsp_angle_estimate   (rsp_angle_estimate),
      .rsp_speed_estimate   (rsp_speed_estimate),
      .rsp_current_estimate (rsp_current_estimate)
   );

endmodule

FILE: hdl/dcmso_ctrl.sv
// dcmso_ctrl: sequencer for the observer update; walks the step schedule and
// owns the handshake and result valid. Depends on dcmso_pkg.
module dcmso_ctrl
   import dcmso_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_WB   = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              wb_fire;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign wb_fire   = (state_ff == ST_WB) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_W'(STEP_COUNT - 1)) begin
               state_in = ST_WB;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_WB: begin
            if (wb_fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (state_ff == ST_RUN) begin
         cmd = step_cmd(step_ff);
      end else begin
         cmd = '0;
      end
      cmd.load = accept;
      cmd.wb   = wb_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/dcmso_datapath.sv
// dcmso_datapath: channel store, shared split multiplier with rounding,
// accumulator with saturation, and result register. Depends on dcmso_pkg.
module dcmso_datapath
   import dcmso_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_cmd_type              cmd,
   input  logic                     req_chn,
   input  logic signed [VOLT_W-1:0] req_voltage,
   input  logic signed [ANG_W-1:0]  req_measured_angle,
   output logic                     rsp_out_channel,
   output logic signed [EST_W-1:0]  rsp_angle_estimate,
   output logic signed [EST_W-1:0]  rsp_speed_estimate,
   output logic signed [EST_W-1:0]  rsp_current_estimate
);

   // channel store
   logic signed [EST_W-1:0] store_cur_ff [CHANNELS];
   logic signed [EST_W-1:0] store_spd_ff [CHANNELS];
   logic signed [EST_W-1:0] store_ang_ff [CHANNELS];

   // working registers
   logic                     chn_ff, chn_in;
   logic                     ok_ff, ok_in;
   logic [CH_IDX_W-1:0]      idx_ff, idx_in;
   logic signed [VQ_W-1:0]   v_ff, v_in;
   logic signed [OPND_W-1:0] err_ff, err_in;
   logic signed [EST_W-1:0]  cur_ff, cur_in;
   logic signed [EST_W-1:0]  spd_ff, spd_in;
   logic signed [EST_W-1:0]  ang_ff, ang_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic [COEF_W-1:0]        cmag_ff, cmag_in;
   logic                     sgn_ff, sgn_in;
   logic [LO_PROD_W-1:0]     lo_ff, lo_in;
   logic [HI_PROD_W-1:0]     hi_ff, hi_in;
   logic                     sgn_m_ff, sgn_m_in;
   logic [RND_W-1:0]         rnd_ff, rnd_in;
   logic                     sgn_r_ff, sgn_r_in;
   logic                     out_chn_ff, out_chn_in;
   logic signed [EST_W-1:0]  out_ang_ff, out_ang_in;
   logic signed [EST_W-1:0]  out_spd_ff, out_spd_in;
   logic signed [EST_W-1:0]  out_cur_ff, out_cur_in;

   // combinational
   logic                     req_ok;
   logic [CH_IDX_W-1:0]      req_idx;
   logic signed [EST_W-1:0]  rd_cur, rd_spd, rd_ang;
   logic signed [EST_W-1:0]  th_q;
   logic signed [OPND_W-1:0] opnd_val;
   logic                     opnd_neg;
   logic [HI_W-1:0]          mul_a;
   logic [HI_PROD_W-1:0]     prod;
   logic [RSUM_W-1:0]        rsum;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  acc_sum;
   logic signed [EST_W-1:0]  est_sat;
   logic                     acc_fits;

   assign req_ok  = (32'(req_chn) < 32'(CHANNELS));
   assign req_idx = CH_IDX_W'(req_chn);
   assign rd_cur  = req_ok ? store_cur_ff[req_idx] : '0;
   assign rd_spd  = req_ok ? store_spd_ff[req_idx] : '0;
   assign rd_ang  = req_ok ? store_ang_ff[req_idx] : '0;
   assign th_q    = {req_measured_angle, 16'b0};

   // operand select and magnitude
   always_comb begin
      case (cmd.opnd)
         OP_CUR:  opnd_val = OPND_W'(cur_ff);
         OP_SPD:  opnd_val = OPND_W'(spd_ff);
         OP_VOLT: opnd_val = OPND_W'(v_ff);
         OP_ERR:  opnd_val = err_ff;
         default: opnd_val = '0;
      endcase
   end
   assign opnd_neg = opnd_val[OPND_W-1];

   // one multiplier, low slice then high slice of the magnitude
   assign mul_a = cmd.mul_hi ? mag_ff[MAG_W-1:LO_W] : {1'b0, mag_ff[LO_W-1:0]};
   assign prod  = HI_PROD_W'(mul_a) * HI_PROD_W'(cmag_ff);

   // round to nearest, ties away from zero on the magnitude
   assign rsum = (RSUM_W'(hi_ff) << LO_W) + RSUM_W'(lo_ff)
               + (RSUM_W'(1) << (Q_SHIFT - 1));

   assign term    = sgn_r_ff ? -ACC_W'(rnd_ff) : ACC_W'(rnd_ff);
   assign acc_sum = acc_ff + term;

   // clamp to the 48-bit estimate range
   assign acc_fits = (acc_ff[ACC_W-1:EST_W-1] == '0) || (acc_ff[ACC_W-1:EST_W-1] == '1);
   always_comb begin
      if (acc_fits) begin
         est_sat = acc_ff[EST_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         est_sat = {1'b1, {(EST_W-1){1'b0}}};
      end else begin
         est_sat = {1'b0, {(EST_W-1){1'b1}}};
      end
   end

   always_comb begin
      chn_in     = chn_ff;
      ok_in      = ok_ff;
      idx_in     = idx_ff;
      v_in       = v_ff;
      err_in     = err_ff;
      cur_in     = cur_ff;
      spd_in     = spd_ff;
      ang_in     = ang_ff;
      acc_in     = acc_ff;
      mag_in     = mag_ff;
      cmag_in    = cmag_ff;
      sgn_in     = sgn_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      sgn_m_in   = sgn_m_ff;
      rnd_in     = rnd_ff;
      sgn_r_in   = sgn_r_ff;
      out_chn_in = out_chn_ff;
      out_ang_in = out_ang_ff;
      out_spd_in = out_spd_ff;
      out_cur_in = out_cur_ff;

      if (cmd.load) begin
         chn_in = req_chn;
         ok_in  = req_ok;
         idx_in = req_idx;
         v_in   = {req_voltage, 22'b0};
         err_in = OPND_W'(th_q) - OPND_W'(rd_ang);
         cur_in = rd_cur;
         spd_in = rd_spd;
         ang_in = rd_ang;
         acc_in = ACC_W'(rd_cur);
      end

      if (cmd.sel_en) begin
         mag_in  = opnd_neg ? MAG_W'(-opnd_val) : MAG_W'(opnd_val);
         cmag_in = coef_mag(cmd.coef);
         sgn_in  = opnd_neg ^ coef_neg(cmd.coef);
      end

      if (cmd.mul_lo) begin
         lo_in = prod[LO_PROD_W-1:0];
      end
      if (cmd.mul_hi) begin
         hi_in    = prod;
         sgn_m_in = sgn_ff;
      end

      if (cmd.rnd_en) begin
         rnd_in   = rsum[RSUM_W-1:Q_SHIFT];
         sgn_r_in = sgn_m_ff;
      end

      if (cmd.acc_en) begin
         acc_in = acc_sum;
      end

      // finished estimate; accumulator restarts from the next old estimate
      if (cmd.fin_en) begin
         case (cmd.fin_tgt)
            TGT_CUR: begin
               cur_in = est_sat;
               acc_in = ACC_W'(spd_ff);
            end
            TGT_SPD: begin
               spd_in = est_sat;
               acc_in = ACC_W'(ang_ff);
            end
            TGT_ANG: begin
               ang_in = est_sat;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end

      if (cmd.wb) begin
         out_chn_in = chn_ff;
         out_ang_in = ok_ff ? ang_ff : '0;
         out_spd_in = ok_ff ? spd_ff : '0;
         out_cur_in = ok_ff ? cur_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      chn_ff     <= chn_in;
      ok_ff      <= ok_in;
      idx_ff     <= idx_in;
      v_ff       <= v_in;
      err_ff     <= err_in;
      cur_ff     <= cur_in;
      spd_ff     <= spd_in;
      ang_ff     <= ang_in;
      acc_ff     <= acc_in;
      mag_ff     <= mag_in;
      cmag_ff    <= cmag_in;
      sgn_ff     <= sgn_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      sgn_m_ff   <= sgn_m_in;
      rnd_ff     <= rnd_in;
      sgn_r_ff   <= sgn_r_in;
      out_chn_ff <= out_chn_in;
      out_ang_ff <= out_ang_in;
      out_spd_ff <= out_spd_in;
      out_cur_ff <= out_cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CHANNELS; k++) begin
            store_cur_ff[k] <= '0;
            store_spd_ff[k] <= '0;
            store_ang_ff[k] <= '0;
         end
      end else if (cmd.wb && ok_ff) begin
         store_cur_ff[idx_ff] <= cur_ff;
         store_spd_ff[idx_ff] <= spd_ff;
         store_ang_ff[idx_ff] <= ang_ff;
      end
   end

   assign rsp_out_channel      = out_chn_ff;
   assign rsp_angle_estimate   = out_ang_ff;
   assign rsp_speed_estimate   = out_spd_ff;
   assign rsp_current_estimate = out_cur_ff;

endmodule
